/* rtl/ifna_pkg.sv */
package ifna_pkg;

   // fixed field widths
   localparam int CH_W    = 8;
   localparam int PIX_W   = 3 * CH_W;
   localparam int POS_W   = 8;
   localparam int CMD_W   = 2;
   localparam int CSR_A_W = 2;
   localparam int CSR_D_W = 9;
   localparam int RGN_P_W = 8;
   localparam int RGN_S_W = 9;

   // coordinates and region bounds, wide enough for the largest frame
   localparam int COORD_W = 13;

   // per-channel sum of four neighbours
   localparam int ACC_W = CH_W + 2;

   // command codes
   localparam logic [CMD_W-1:0] CMD_WRITE = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_PASS  = 2'd2;

   // register indexes
   localparam logic [CSR_A_W-1:0] REG_REGION_X = 2'd0;
   localparam logic [CSR_A_W-1:0] REG_REGION_Y = 2'd1;
   localparam logic [CSR_A_W-1:0] REG_REGION_W = 2'd2;
   localparam logic [CSR_A_W-1:0] REG_REGION_H = 2'd3;

   // neighbour select, in fetch order
   localparam logic [1:0] NB_RIGHT = 2'd0;
   localparam logic [1:0] NB_LEFT  = 2'd1;
   localparam logic [1:0] NB_DOWN  = 2'd2;
   localparam logic [1:0] NB_UP    = 2'd3;

   // response kinds
   localparam logic [1:0] RSP_ZERO = 2'd0;
   localparam logic [1:0] RSP_READ = 2'd1;
   localparam logic [1:0] RSP_DONE = 2'd2;

   // controller to datapath commands
   typedef struct packed {
      logic       latch;
      logic       pos_write;
      logic       rd_pixel;
      logic [1:0] nb_sel;
      logic       acc_load;
      logic       acc_add;
      logic       pix_write;
      logic       col_init;
      logic       row_init;
      logic       col_next;
      logic       row_next;
      logic       rsp_set;
      logic [1:0] rsp_kind;
   } ifna_ctrl_type;

   // datapath to controller status
   typedef struct packed {
      logic col_ok;
      logic row_ok;
   } ifna_stat_type;

endpackage

/* rtl/ifna_ram.sv */
module ifna_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 65536
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // one write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

/* rtl/ifna_ctrl.sv */
module ifna_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [1:0]              req_command,
   input  ifna_pkg::ifna_stat_type stat,
   output ifna_pkg::ifna_ctrl_type ctrl,
   output logic                    busy
);
   import ifna_pkg::*;

   localparam logic [3:0] S_IDLE      = 4'd0;
   localparam logic [3:0] S_WRITE     = 4'd1;
   localparam logic [3:0] S_NOP       = 4'd2;
   localparam logic [3:0] S_READ_ADDR = 4'd3;
   localparam logic [3:0] S_READ_DATA = 4'd4;
   localparam logic [3:0] S_PASS_INIT = 4'd5;
   localparam logic [3:0] S_PASS_COL  = 4'd6;
   localparam logic [3:0] S_PASS_ROW  = 4'd7;
   localparam logic [3:0] S_PASS_PIX  = 4'd8;
   localparam logic [3:0] S_PASS_END  = 4'd9;

   localparam logic [2:0] PH_LAST = 3'd4;

   logic [3:0] state_ff, state_in;
   logic [2:0] phase_ff, phase_in;

   assign busy = (state_ff != S_IDLE);

   // next state and datapath commands
   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      ctrl     = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               ctrl.latch = 1'b1;
               unique case (req_command)
                  CMD_WRITE: state_in = S_WRITE;
                  CMD_READ:  state_in = S_READ_ADDR;
                  CMD_PASS:  state_in = S_PASS_INIT;
                  default:   state_in = S_NOP;
               endcase
            end
         end
         S_WRITE: begin
            ctrl.pos_write = 1'b1;
            ctrl.rsp_set   = 1'b1;
            ctrl.rsp_kind  = RSP_ZERO;
            state_in       = S_IDLE;
         end
         S_NOP: begin
            ctrl.rsp_set  = 1'b1;
            ctrl.rsp_kind = RSP_ZERO;
            state_in      = S_IDLE;
         end
         S_READ_ADDR: begin
            state_in = S_READ_DATA;
         end
         S_READ_DATA: begin
            ctrl.rsp_set  = 1'b1;
            ctrl.rsp_kind = RSP_READ;
            state_in      = S_IDLE;
         end
         S_PASS_INIT: begin
            ctrl.col_init = 1'b1;
            state_in      = S_PASS_COL;
         end
         S_PASS_COL: begin
            if (stat.col_ok) begin
               ctrl.row_init = 1'b1;
               state_in      = S_PASS_ROW;
            end else begin
               state_in = S_PASS_END;
            end
         end
         S_PASS_ROW: begin
            if (stat.row_ok) begin
               phase_in = '0;
               state_in = S_PASS_PIX;
            end else begin
               ctrl.col_next = 1'b1;
               state_in      = S_PASS_COL;
            end
         end
         S_PASS_PIX: begin
            // four neighbour reads, each summed in the cycle after its read, then write back
            ctrl.rd_pixel = 1'b1;
            ctrl.nb_sel   = phase_ff[1:0];
            ctrl.acc_load = (phase_ff == 3'd1);
            ctrl.acc_add  = (phase_ff == 3'd2) || (phase_ff == 3'd3);
            if (phase_ff == PH_LAST) begin
               ctrl.pix_write = 1'b1;
               ctrl.row_next  = 1'b1;
               state_in       = S_PASS_ROW;
            end else begin
               phase_in = phase_ff + 3'd1;
            end
         end
         S_PASS_END: begin
            ctrl.rsp_set  = 1'b1;
            ctrl.rsp_kind = RSP_DONE;
            state_in      = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         phase_ff <= '0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
      end
   end

endmodule

/* rtl/ifna_datapath.sv */
module ifna_datapath #(
   parameter int FRAME_WIDTH  = 256,
   parameter int FRAME_HEIGHT = 256
) (
   input  logic                            clock,
   input  logic                            reset,
   input  ifna_pkg::ifna_ctrl_type         ctrl,
   output ifna_pkg::ifna_stat_type         stat,
   input  logic [ifna_pkg::POS_W-1:0]      req_pos_x,
   input  logic [ifna_pkg::POS_W-1:0]      req_pos_y,
   input  logic [ifna_pkg::CH_W-1:0]       req_in_red,
   input  logic [ifna_pkg::CH_W-1:0]       req_in_green,
   input  logic [ifna_pkg::CH_W-1:0]       req_in_blue,
   input  logic                            csr_write,
   input  logic [ifna_pkg::CSR_A_W-1:0]    csr_index,
   input  logic [ifna_pkg::CSR_D_W-1:0]    csr_data,
   output logic                            rsp_valid,
   output logic [ifna_pkg::CH_W-1:0]       rsp_out_red,
   output logic [ifna_pkg::CH_W-1:0]       rsp_out_green,
   output logic [ifna_pkg::CH_W-1:0]       rsp_out_blue,
   output logic                            rsp_pass_done
);
   import ifna_pkg::*;

   localparam int XW     = $clog2(FRAME_WIDTH);
   localparam int YW     = $clog2(FRAME_HEIGHT);
   localparam int ADDR_W = XW + YW;
   localparam int DEPTH  = 2 ** ADDR_W;

   localparam logic [COORD_W-1:0] X_MAX = COORD_W'(FRAME_WIDTH - 1);
   localparam logic [COORD_W-1:0] Y_MAX = COORD_W'(FRAME_HEIGHT - 1);
   localparam logic [COORD_W-1:0] X_LIM = COORD_W'(FRAME_WIDTH);
   localparam logic [COORD_W-1:0] Y_LIM = COORD_W'(FRAME_HEIGHT);

   logic [RGN_P_W-1:0] region_x_ff, region_y_ff;
   logic [RGN_S_W-1:0] region_w_ff, region_h_ff;
   logic [POS_W-1:0]   pos_x_ff, pos_y_ff;
   logic [PIX_W-1:0]   pix_ff;
   logic [COORD_W-1:0] cur_x_ff, cur_x_in, cur_y_ff, cur_y_in;
   logic [ACC_W-1:0]   acc_ff [3];
   logic               rsp_valid_ff;
   logic [CH_W-1:0]    rsp_red_ff, rsp_green_ff, rsp_blue_ff;
   logic               rsp_done_ff;

   logic [COORD_W-1:0] pos_x_c, pos_y_c, nb_x, nb_y, x_end, y_end;
   logic               pos_on_frame;
   logic               wr_en;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   logic [PIX_W-1:0]   wr_data, rd_data;
   logic [PIX_W-1:0]   avg_pix;
   logic [ACC_W-1:0]   total;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         region_x_ff <= '0;
         region_y_ff <= '0;
         region_w_ff <= '0;
         region_h_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            REG_REGION_X: region_x_ff <= csr_data[RGN_P_W-1:0];
            REG_REGION_Y: region_y_ff <= csr_data[RGN_P_W-1:0];
            REG_REGION_W: region_w_ff <= csr_data;
            REG_REGION_H: region_h_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // command fields held for the whole command
   always_ff @(posedge clock) begin
      if (ctrl.latch) begin
         pos_x_ff <= req_pos_x;
         pos_y_ff <= req_pos_y;
         pix_ff   <= {req_in_red, req_in_green, req_in_blue};
      end
   end

   assign pos_x_c      = COORD_W'(pos_x_ff);
   assign pos_y_c      = COORD_W'(pos_y_ff);
   assign pos_on_frame = (pos_x_c < X_LIM) && (pos_y_c < Y_LIM);

   // sweep counters, column outer, row inner
   assign x_end = COORD_W'(region_x_ff) + COORD_W'(region_w_ff);
   assign y_end = COORD_W'(region_y_ff) + COORD_W'(region_h_ff);

   always_comb begin
      cur_x_in = cur_x_ff;
      cur_y_in = cur_y_ff;
      if (ctrl.col_init) begin
         cur_x_in = COORD_W'(region_x_ff);
      end else if (ctrl.col_next) begin
         cur_x_in = cur_x_ff + COORD_W'(1);
      end
      if (ctrl.row_init) begin
         cur_y_in = COORD_W'(region_y_ff);
      end else if (ctrl.row_next) begin
         cur_y_in = cur_y_ff + COORD_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_x_ff <= '0;
         cur_y_ff <= '0;
      end else begin
         cur_x_ff <= cur_x_in;
         cur_y_ff <= cur_y_in;
      end
   end

   assign stat.col_ok = (cur_x_ff < x_end) && (cur_x_ff < X_LIM);
   assign stat.row_ok = (cur_y_ff < y_end) && (cur_y_ff < Y_LIM);

   // neighbour coordinates, clamped to the frame edge
   always_comb begin
      nb_x = cur_x_ff;
      nb_y = cur_y_ff;
      unique case (ctrl.nb_sel)
         NB_RIGHT: nb_x = (cur_x_ff == X_MAX) ? cur_x_ff : cur_x_ff + COORD_W'(1);
         NB_LEFT:  nb_x = (cur_x_ff == '0) ? cur_x_ff : cur_x_ff - COORD_W'(1);
         NB_DOWN:  nb_y = (cur_y_ff == Y_MAX) ? cur_y_ff : cur_y_ff + COORD_W'(1);
         NB_UP:    nb_y = (cur_y_ff == '0) ? cur_y_ff : cur_y_ff - COORD_W'(1);
         default: ;
      endcase
   end

   // per-channel neighbour sums, divided by four for the average
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         total = acc_ff[c] + ACC_W'(rd_data[c*CH_W +: CH_W]);
         avg_pix[c*CH_W +: CH_W] = total[ACC_W-1:2];
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < 3; c++) begin
         if (ctrl.acc_load) begin
            acc_ff[c] <= ACC_W'(rd_data[c*CH_W +: CH_W]);
         end else if (ctrl.acc_add) begin
            acc_ff[c] <= acc_ff[c] + ACC_W'(rd_data[c*CH_W +: CH_W]);
         end
      end
   end

   // frame store ports
   assign wr_en   = (ctrl.pos_write && pos_on_frame) || ctrl.pix_write;
   assign wr_addr = ctrl.pix_write ? {cur_y_ff[YW-1:0], cur_x_ff[XW-1:0]}
                                   : {pos_y_c[YW-1:0], pos_x_c[XW-1:0]};
   assign wr_data = ctrl.pix_write ? avg_pix : pix_ff;
   assign rd_addr = ctrl.rd_pixel ? {nb_y[YW-1:0], nb_x[XW-1:0]}
                                  : {pos_y_c[YW-1:0], pos_x_c[XW-1:0]};

   ifna_ram #(
      .WIDTH (PIX_W),
      .DEPTH (DEPTH)
   ) u_frame (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // response registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= ctrl.rsp_set;
      end
   end

   // channels are zero unless an on-frame read
   always_ff @(posedge clock) begin
      if (ctrl.rsp_set) begin
         unique case (ctrl.rsp_kind)
            RSP_READ: begin
               rsp_red_ff   <= pos_on_frame ? rd_data[3*CH_W-1:2*CH_W] : '0;
               rsp_green_ff <= pos_on_frame ? rd_data[2*CH_W-1:CH_W] : '0;
               rsp_blue_ff  <= pos_on_frame ? rd_data[CH_W-1:0] : '0;
               rsp_done_ff  <= 1'b0;
            end
            RSP_DONE: begin
               rsp_red_ff   <= '0;
               rsp_green_ff <= '0;
               rsp_blue_ff  <= '0;
               rsp_done_ff  <= 1'b1;
            end
            default: begin
               rsp_red_ff   <= '0;
               rsp_green_ff <= '0;
               rsp_blue_ff  <= '0;
               rsp_done_ff  <= 1'b0;
            end
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_red   = rsp_red_ff;
   assign rsp_out_green = rsp_green_ff;
   assign rsp_out_blue  = rsp_blue_ff;
   assign rsp_pass_done = rsp_done_ff;

endmodule

/* rtl/inplace_four_neighbour_average.sv */
// the result strobe is registered from the write state for a write and from the data
// state, after the address state, for a read; a pass reads four neighbours and writes
// back each region pixel on the single frame store, with a row check per pixel
// one command at a time; busy stays high until the command's result is set up
// the receiver cannot stall; each result is strobed for exactly one cycle
// synchronous reset clears control and region registers; frame contents are not cleared
module inplace_four_neighbour_average #(
   parameter int FRAME_WIDTH  = 256,
   parameter int FRAME_HEIGHT = 256
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         start,
   output logic                         busy,
   input  logic [ifna_pkg::CMD_W-1:0]   req_command,
   input  logic [ifna_pkg::POS_W-1:0]   req_pos_x,
   input  logic [ifna_pkg::POS_W-1:0]   req_pos_y,
   input  logic [ifna_pkg::CH_W-1:0]    req_in_red,
   input  logic [ifna_pkg::CH_W-1:0]    req_in_green,
   input  logic [ifna_pkg::CH_W-1:0]    req_in_blue,
   output logic                         rsp_valid,
   output logic [ifna_pkg::CH_W-1:0]    rsp_out_red,
   output logic [ifna_pkg::CH_W-1:0]    rsp_out_green,
   output logic [ifna_pkg::CH_W-1:0]    rsp_out_blue,
   output logic                         rsp_pass_done,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [ifna_pkg::CSR_A_W-1:0] csr_index,
   input  logic [ifna_pkg::CSR_D_W-1:0] csr_data
);
   import ifna_pkg::*;

   ifna_ctrl_type ctrl;
   ifna_stat_type stat;

   // register writes are always taken
   assign csr_ready = 1'b1;

   ifna_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .stat        (stat),
      .ctrl        (ctrl),
      .busy        (busy)
   );

   ifna_datapath #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .stat          (stat),
      .req_pos_x     (req_pos_x),
      .req_pos_y     (req_pos_y),
      .req_in_red    (req_in_red),
      .req_in_green  (req_in_green),
      .req_in_blue   (req_in_blue),
      .csr_write     (csr_valid && csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .rsp_valid     (rsp_valid),
      .rsp_out_red   (rsp_out_red),
      .rsp_out_green (rsp_out_green),
      .rsp_out_blue  (rsp_out_blue),
      .rsp_pass_done (rsp_pass_done)
   );

endmodule
